// ===== rtl/slnu_pkg.sv =====
// package: shared types, constants and utf-8 encoding helpers for the line normaliser
`timescale 1ns / 1ps
package slnu_pkg;

    // default line buffer length and the safety margin below it
    localparam int LINE_LEN_DEF = 4096;
    localparam int LIMIT_MARGIN = 6 * 6;

    // per-item operation list
    localparam int NUM_OPS  = 6;
    localparam int OP_IDX_W = 3;

    // encoding modes
    localparam logic [2:0] MODE_UNK  = 3'd0;
    localparam logic [2:0] MODE_UTF8 = 3'd1;
    localparam logic [2:0] MODE_LE   = 3'd2;
    localparam logic [2:0] MODE_BE   = 3'd3;
    localparam logic [2:0] MODE_LAT  = 3'd4;

    // code points of interest
    localparam logic [31:0] CP_LF      = 32'h0000_000a;
    localparam logic [31:0] CP_CR      = 32'h0000_000d;
    localparam logic [31:0] CP_SPACE   = 32'h0000_0020;
    localparam logic [31:0] CP_REPL    = 32'h0000_fffd;
    localparam logic [31:0] CP_BOM     = 32'h0000_feff;
    localparam logic [31:0] CP_SWAP    = 32'h0000_fffe;
    localparam logic [31:0] CP_HI      = 32'h0000_d800;
    localparam logic [31:0] CP_LO      = 32'h0000_dc00;
    localparam logic [31:0] CP_SUR_END = 32'h0000_e000;
    localparam logic [31:0] CP_PLANE1  = 32'h0001_0000;

    // operation kinds held in the list
    typedef enum logic [1:0] {
        OP_PREV,
        OP_PROC,
        OP_RAW,
        OP_END
    } t_op;

    // commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;
        logic next_op;
        logic set_prev;
        logic space;
        logic byte_start;
        logic emit_byte;
        logic word_done;
        logic emit_eol;
        logic eol_tl;
        logic set_stop;
        logic finish_push;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_valid;
        logic ops_done;
        logic stopped;
        t_op  kind;
        logic is_nl;
        logic nl_skip;
        logic is_space;
        logic k_last;
        logic over_limit;
        logic emit_ok;
        logic out_free;
        logic pend_v;
    } t_sts;

    // number of utf-8 bytes for a code point, zero takes the two byte form
    function automatic logic [2:0] utf8_len(input logic [31:0] cp);
        logic [2:0] n;
        if (cp == 32'd0)               n = 3'd2;
        else if (cp < 32'h80)          n = 3'd1;
        else if (cp < 32'h800)         n = 3'd2;
        else if (cp < 32'h1_0000)      n = 3'd3;
        else if (cp < 32'h20_0000)     n = 3'd4;
        else if (cp < 32'h400_0000)    n = 3'd5;
        else                           n = 3'd6;
        return n;
    endfunction

    // byte k of the n byte encoding of cp
    function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [2:0] n,
                                             input logic [2:0] k);
        logic [7:0]  r;
        logic [31:0] sh;
        if (n == 3'd1) begin
            r = cp[7:0];
        end else if (k == 3'd0) begin
            sh = cp >> (6 * (n - 3'd1));
            r  = 8'(16'hff00 >> n) | (sh[7:0] & (8'hff >> (n + 3'd1)));
        end else begin
            sh = cp >> (6 * (n - 3'd1 - k));
            r  = 8'h80 | {2'b00, sh[5:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/slnu_cfg_if.sv =====
// interface: configuration write channel
`timescale 1ns / 1ps
interface slnu_cfg_if;
    logic valid;
    logic ready;
    logic decode_text;
    modport source (output valid, decode_text, input ready);
    modport sink (input valid, decode_text, output ready);
endinterface

// ===== rtl/slnu_in_if.sv =====
// interface: input byte channel
`timescale 1ns / 1ps
interface slnu_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;
    modport source (output valid, action, in_byte, input ready);
    modport sink (input valid, action, in_byte, output ready);
endinterface

// ===== rtl/slnu_out_if.sv =====
// interface: output byte channel
`timescale 1ns / 1ps
interface slnu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [12:0] spaces_before;
    logic        end_of_line;
    logic        line_too_long;
    logic        last;
    modport source (output valid, out_byte, spaces_before, end_of_line, line_too_long, last,
                    input ready);
    modport sink (input valid, out_byte, spaces_before, end_of_line, line_too_long, last,
                  output ready);
endinterface

// ===== rtl/slnu_ctrl.sv =====
// controller: sequences the operation list of one item and the output handshake
`timescale 1ns / 1ps
module slnu_ctrl
    import slnu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_BYTES    = 5'b00100,
        S_CHECK    = 5'b01000,
        S_FINISH   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.stopped || i_sts.ops_done) begin
                    n_state = S_FINISH;
                end else begin
                    case (i_sts.kind)
                        OP_PREV: begin
                            o_cmd.set_prev = 1'b1;
                            o_cmd.next_op  = 1'b1;
                        end
                        OP_END: begin
                            if (i_sts.emit_ok) begin
                                o_cmd.emit_eol = 1'b1;
                                o_cmd.set_stop = 1'b1;
                                o_cmd.next_op  = 1'b1;
                            end
                        end
                        default: begin
                            if (i_sts.is_nl) begin
                                if (i_sts.nl_skip) begin
                                    o_cmd.set_prev = 1'b1;
                                    o_cmd.next_op  = 1'b1;
                                end else if (i_sts.emit_ok) begin
                                    o_cmd.emit_eol = 1'b1;
                                    o_cmd.set_prev = 1'b1;
                                    o_cmd.next_op  = 1'b1;
                                end
                            end else if (i_sts.is_space) begin
                                o_cmd.set_prev = 1'b1;
                                o_cmd.space    = 1'b1;
                                if (i_sts.kind == OP_PROC) begin
                                    n_state = S_CHECK;
                                end else begin
                                    o_cmd.next_op = 1'b1;
                                end
                            end else begin
                                o_cmd.set_prev   = 1'b1;
                                o_cmd.byte_start = 1'b1;
                                n_state          = S_BYTES;
                            end
                        end
                    endcase
                end
            end
            S_BYTES: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.word_done = 1'b1;
                        if (i_sts.kind == OP_PROC) begin
                            n_state = S_CHECK;
                        end else begin
                            o_cmd.next_op = 1'b1;
                            n_state       = S_DISPATCH;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.over_limit) begin
                    if (i_sts.emit_ok) begin
                        o_cmd.emit_eol = 1'b1;
                        o_cmd.eol_tl   = 1'b1;
                        o_cmd.set_stop = 1'b1;
                        n_state        = S_FINISH;
                    end
                end else begin
                    o_cmd.next_op = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_FINISH: begin
                if (!i_sts.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.finish_push = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/slnu_dp.sv =====
// datapath: decoder state, operation list, utf-8 byte engine, line counters and output stage
`timescale 1ns / 1ps
module slnu_dp
    import slnu_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    slnu_cfg_if.sink     i_cfg,
    slnu_in_if.sink      i_in,
    slnu_out_if.source   o_out,
    input  t_cmd         i_cmd,
    output t_sts         o_sts
);

    localparam int CntW       = $clog2(LINE_LEN + 64);
    localparam int LINE_LIMIT = LINE_LEN - LIMIT_MARGIN;

    // decoder state
    logic                r_dt;
    logic [2:0]          r_mode;
    logic                r_first;
    logic [31:0]         r_acc;
    logic [2:0]          r_left;
    logic [2:0]          r_total;
    logic [8:0]          r_held;
    logic [31:0]         r_prev;
    logic                r_stop;

    // line counters
    logic [CntW-1:0]     r_cnt;
    logic [CntW-1:0]     r_hsp;

    // operation list
    t_op                 r_op_kind [NUM_OPS];
    logic [31:0]         r_op_cp   [NUM_OPS];
    logic [OP_IDX_W-1:0] r_nops;
    logic [OP_IDX_W-1:0] r_idx;
    logic [2:0]          r_k;

    // pending and output stages
    logic                r_pend_v;
    logic [7:0]          r_pend_byte;
    logic [12:0]         r_pend_sp;
    logic                r_pend_eol;
    logic                r_pend_tl;
    logic                r_out_v;
    logic [7:0]          r_out_byte;
    logic [12:0]         r_out_sp;
    logic                r_out_eol;
    logic                r_out_tl;
    logic                r_out_last;

    // next decoder state
    logic [2:0]          n_mode;
    logic                n_first;
    logic [31:0]         n_acc;
    logic [2:0]          n_left;
    logic [2:0]          n_total;
    logic [8:0]          n_held;
    t_op                 n_op_kind [NUM_OPS];
    logic [31:0]         n_op_cp   [NUM_OPS];
    logic [OP_IDX_W-1:0] n_nops;

    // raw flush of a broken sequence
    logic [2:0]          f_used;
    logic [7:0]          f_lead;
    logic [7:0]          f_cont [4];

    logic                load;
    logic                cfg_fire;
    logic [31:0]         cur_cp;
    t_op                 cur_kind;
    logic [2:0]          cur_n;
    logic                out_free;
    logic [7:0]          e_byte;
    logic [12:0]         e_sp;

    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_cmd.in_ready;
    assign load        = i_in.valid && i_cmd.in_ready;

    // flush values from the accumulated lead and continuation bits
    always_comb begin
        logic [2:0]  used;
        logic [31:0] sh;
        used = 3'(r_total - r_left);
        if (r_total > 3'd5 || used > 3'd4) begin
            used = 3'd0;
        end
        f_used = used;
        sh     = r_acc >> (6 * used);
        f_lead = 8'(16'hff80 >> r_total) | sh[7:0];
        for (int j = 1; j <= 4; j++) begin
            if (3'(j) <= used) begin
                sh          = r_acc >> (6 * (int'(used) - j));
                f_cont[j-1] = 8'h80 | {2'b00, sh[5:0]};
            end else begin
                f_cont[j-1] = 8'h00;
            end
        end
    end

    // decode one item into next state and an operation list
    always_comb begin
        logic [2:0]  m;
        logic [31:0] bb;
        logic [31:0] h;
        logic [31:0] u;
        logic [31:0] acc2;
        logic [2:0]  n;
        logic        pend;
        logic        low;
        logic        lead_path;
        n_mode  = r_mode;
        n_first = r_first;
        n_acc   = r_acc;
        n_left  = r_left;
        n_total = r_total;
        n_held  = r_held;
        n_nops  = '0;
        for (int i = 0; i < NUM_OPS; i++) begin
            n_op_kind[i] = OP_PREV;
            n_op_cp[i]   = '0;
        end
        m         = r_mode;
        bb        = {24'b0, i_in.in_byte};
        h         = {24'b0, r_held[7:0]};
        u         = '0;
        acc2      = '0;
        n         = '0;
        low       = 1'b0;
        lead_path = 1'b0;
        pend      = (r_prev >= CP_HI) && (r_prev < CP_LO);
        if (!i_in.action) begin
            n_first = 1'b1;
            if (!r_first && r_mode == MODE_UNK && bb == 32'd0) begin
                m = MODE_BE;
            end
            n_mode = m;
            if (!r_dt || m >= MODE_LAT) begin
                n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = bb; n_nops = n_nops + 3'd1;
            end else if (m <= MODE_UTF8) begin
                if (m == MODE_UNK && r_held[8]) begin
                    // second byte of a possible byte order mark
                    n_held = '0;
                    if (h == 32'hff && bb == 32'hfe) begin
                        n_mode = MODE_LE;
                        n_op_kind[n_nops] = OP_PREV; n_op_cp[n_nops] = h;
                        n_nops = n_nops + 3'd1;
                    end else if (h == 32'hfe && bb == 32'hff) begin
                        n_mode = MODE_BE;
                        n_op_kind[n_nops] = OP_PREV; n_op_cp[n_nops] = h;
                        n_nops = n_nops + 3'd1;
                    end else begin
                        n_mode = MODE_LAT;
                        n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = h;
                        n_nops = n_nops + 3'd1;
                        n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = bb;
                        n_nops = n_nops + 3'd1;
                    end
                end else begin
                    lead_path = 1'b1;
                    if (r_left != 3'd0) begin
                        if (bb[7:6] == 2'b10) begin
                            // continuation byte
                            acc2      = {r_acc[25:0], bb[5:0]};
                            n_acc     = acc2;
                            n_left    = r_left - 3'd1;
                            lead_path = 1'b0;
                            if (r_left == 3'd1) begin
                                n_mode  = MODE_UTF8;
                                n_total = '0;
                                n_op_kind[n_nops] = (acc2 == CP_BOM) ? OP_PREV : OP_PROC;
                                n_op_cp[n_nops]   = acc2;
                                n_nops = n_nops + 3'd1;
                            end
                        end else if (m == MODE_UNK) begin
                            // detection failed, replay the sequence as latin-1
                            n_op_kind[n_nops] = OP_RAW; n_op_cp[n_nops] = {24'b0, f_lead};
                            n_nops = n_nops + 3'd1;
                            for (int j = 1; j <= 4; j++) begin
                                if (3'(j) <= f_used) begin
                                    n_op_kind[n_nops] = OP_RAW;
                                    n_op_cp[n_nops]   = {24'b0, f_cont[j-1]};
                                    n_nops = n_nops + 3'd1;
                                end
                            end
                            n_left    = '0;
                            n_total   = '0;
                            n_mode    = MODE_LAT;
                            lead_path = 1'b0;
                            n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = bb;
                            n_nops = n_nops + 3'd1;
                        end else begin
                            n_left  = '0;
                            n_total = '0;
                            n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = CP_REPL;
                            n_nops = n_nops + 3'd1;
                        end
                    end
                    if (lead_path) begin
                        if (bb < 32'h80) begin
                            n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = bb;
                            n_nops = n_nops + 3'd1;
                        end else if (bb < 32'hc0) begin
                            if (m == MODE_UNK) begin
                                n_mode = MODE_LAT;
                                n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = bb;
                            end else begin
                                n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = CP_REPL;
                            end
                            n_nops = n_nops + 3'd1;
                        end else if (bb < 32'hfe) begin
                            // lead byte of a multibyte sequence
                            if (bb < 32'he0)      n = 3'd1;
                            else if (bb < 32'hf0) n = 3'd2;
                            else if (bb < 32'hf8) n = 3'd3;
                            else if (bb < 32'hfc) n = 3'd4;
                            else                  n = 3'd5;
                            n_acc   = bb & (32'h3f >> n);
                            n_left  = n;
                            n_total = n;
                        end else if (m == MODE_UNK) begin
                            n_held = {1'b1, bb[7:0]};
                        end else begin
                            n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = CP_REPL;
                            n_nops = n_nops + 3'd1;
                        end
                    end
                end
            end else begin
                // utf-16 byte pairing and surrogate handling
                if (!r_held[8]) begin
                    n_held = {1'b1, bb[7:0]};
                end else begin
                    n_held = '0;
                    u = (m == MODE_LE) ? {16'b0, bb[7:0], r_held[7:0]}
                                       : {16'b0, r_held[7:0], bb[7:0]};
                    low = (u >= CP_LO) && (u < CP_SUR_END);
                    if (pend && !low) begin
                        n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = CP_REPL;
                        n_nops = n_nops + 3'd1;
                        pend = 1'b0;
                    end
                    if (u == CP_SWAP) begin
                        n_mode = (m == MODE_LE) ? MODE_BE : MODE_LE;
                        n_op_kind[n_nops] = OP_PREV; n_op_cp[n_nops] = u;
                    end else if (u == CP_BOM || (u >= CP_HI && u < CP_LO)) begin
                        n_op_kind[n_nops] = OP_PREV; n_op_cp[n_nops] = u;
                    end else if (low) begin
                        n_op_kind[n_nops] = OP_PROC;
                        n_op_cp[n_nops]   = pend ? ({12'b0, r_prev[9:0], u[9:0]} + CP_PLANE1)
                                                 : CP_REPL;
                    end else begin
                        n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = u;
                    end
                    n_nops = n_nops + 3'd1;
                end
            end
        end else begin
            // end of input
            if (r_dt) begin
                if (r_mode == MODE_UNK) begin
                    if (r_held[8]) begin
                        n_held = '0;
                        n_mode = MODE_LAT;
                        n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = h;
                        n_nops = n_nops + 3'd1;
                    end else if (r_left != 3'd0) begin
                        n_mode = MODE_LAT;
                        n_op_kind[n_nops] = OP_RAW; n_op_cp[n_nops] = {24'b0, f_lead};
                        n_nops = n_nops + 3'd1;
                        for (int j = 1; j <= 4; j++) begin
                            if (3'(j) <= f_used) begin
                                n_op_kind[n_nops] = OP_RAW;
                                n_op_cp[n_nops]   = {24'b0, f_cont[j-1]};
                                n_nops = n_nops + 3'd1;
                            end
                        end
                        n_left  = '0;
                        n_total = '0;
                    end
                end else if (r_mode == MODE_UTF8) begin
                    n_left  = '0;
                    n_total = '0;
                end else if (r_mode == MODE_LE || r_mode == MODE_BE) begin
                    n_held = '0;
                    if (pend) begin
                        n_op_kind[n_nops] = OP_PROC; n_op_cp[n_nops] = CP_REPL;
                        n_nops = n_nops + 3'd1;
                    end
                end
            end
            n_op_kind[n_nops] = OP_END; n_op_cp[n_nops] = '0;
            n_nops = n_nops + 3'd1;
        end
    end

    // current operation and byte under emission
    assign cur_cp   = r_op_cp[r_idx];
    assign cur_kind = r_op_kind[r_idx];
    assign cur_n    = utf8_len(cur_cp);
    assign out_free = !r_out_v || o_out.ready;
    assign e_byte   = i_cmd.emit_eol ? 8'h00 : utf8_byte(cur_cp, cur_n, r_k);
    assign e_sp     = (i_cmd.emit_eol || r_k != 3'd0) ? 13'd0 : 13'(r_hsp);

    // status to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.in_valid   = i_in.valid;
        o_sts.ops_done   = (r_idx == r_nops);
        o_sts.stopped    = r_stop;
        o_sts.kind       = cur_kind;
        o_sts.is_nl      = (cur_kind == OP_PROC) && (cur_cp == CP_LF || cur_cp == CP_CR);
        o_sts.nl_skip    = (cur_cp == CP_LF) && (r_prev == CP_CR);
        o_sts.is_space   = (cur_cp == CP_SPACE);
        o_sts.k_last     = (r_k == cur_n - 3'd1);
        o_sts.over_limit = (r_cnt > CntW'(LINE_LIMIT));
        o_sts.emit_ok    = !r_pend_v || out_free;
        o_sts.out_free   = out_free;
        o_sts.pend_v     = r_pend_v;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= 1'b1;
            r_mode   <= MODE_UNK;
            r_first  <= 1'b0;
            r_acc    <= '0;
            r_left   <= '0;
            r_total  <= '0;
            r_held   <= '0;
            r_prev   <= '0;
            r_stop   <= 1'b0;
            r_cnt    <= '0;
            r_hsp    <= '0;
            r_nops   <= '0;
            r_idx    <= '0;
            r_k      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (cfg_fire) begin
                r_dt <= i_cfg.decode_text;
            end
            // item transaction loads the decoder state and the list
            if (load) begin
                r_mode  <= n_mode;
                r_first <= n_first;
                r_acc   <= n_acc;
                r_left  <= n_left;
                r_total <= n_total;
                r_held  <= n_held;
                r_nops  <= n_nops;
                r_idx   <= '0;
            end
            if (i_cmd.next_op) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_cmd.set_prev) begin
                r_prev <= cur_cp;
            end
            if (i_cmd.set_stop) begin
                r_stop <= 1'b1;
            end
            if (i_cmd.byte_start) begin
                r_k <= '0;
            end else if (i_cmd.emit_byte) begin
                r_k <= r_k + 3'd1;
            end
            // line length and held spaces
            if (i_cmd.emit_eol) begin
                r_cnt <= '0;
                r_hsp <= '0;
            end else if (i_cmd.space) begin
                r_cnt <= r_cnt + 1'b1;
                r_hsp <= r_hsp + 1'b1;
            end else if (i_cmd.word_done) begin
                r_cnt <= r_cnt + CntW'(cur_n);
                r_hsp <= '0;
            end
            // pending byte and output register
            if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.emit_byte || i_cmd.emit_eol) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out_v <= 1'b1;
                end
            end else if (i_cmd.finish_push) begin
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < NUM_OPS; i++) begin
                r_op_kind[i] <= n_op_kind[i];
                r_op_cp[i]   <= n_op_cp[i];
            end
        end
        if (i_cmd.emit_byte || i_cmd.emit_eol) begin
            r_pend_byte <= e_byte;
            r_pend_sp   <= e_sp;
            r_pend_eol  <= i_cmd.emit_eol;
            r_pend_tl   <= i_cmd.eol_tl;
        end
        if ((i_cmd.emit_byte || i_cmd.emit_eol) && r_pend_v) begin
            r_out_byte <= r_pend_byte;
            r_out_sp   <= r_pend_sp;
            r_out_eol  <= r_pend_eol;
            r_out_tl   <= r_pend_tl;
            r_out_last <= 1'b0;
        end else if (i_cmd.finish_push) begin
            r_out_byte <= r_pend_byte;
            r_out_sp   <= r_pend_sp;
            r_out_eol  <= r_pend_eol;
            r_out_tl   <= r_pend_tl;
            r_out_last <= 1'b1;
        end
    end

    // output channel
    assign o_out.valid         = r_out_v;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.spaces_before = r_out_sp;
    assign o_out.end_of_line   = r_out_eol;
    assign o_out.line_too_long = r_out_tl;
    assign o_out.last          = r_out_last;

endmodule

// ===== rtl/source_text_line_normalizer_unit.sv =====
// Top level: encoding detection, decoding and utf-8 line output for source text bytes.
// Flow: an item is decoded in its accept cycle into the operation list; the byte engine then
// emits each output byte into the pending register, which moves on to the output register
// when the next byte is emitted; after the last list entry the final result moves from the
// pending register to the output register in the finish state. Throughput: one item at a
// time, taken only when idle; output stalls hold the byte engine and the finish push.
// Reset: synchronous active low; decoding on, encoding unknown, counters and stop flag cleared.
`timescale 1ns / 1ps
module source_text_line_normalizer_unit
    import slnu_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    slnu_cfg_if.sink   i_cfg,
    slnu_in_if.sink    i_in,
    slnu_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    slnu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // decoder and byte engine
    slnu_dp #(
        .LINE_LEN (LINE_LEN)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

// ===== tb/tb_top.sv =====
// testbench: random and directed byte streams checked against a line normaliser predictor
`timescale 1ns / 1ps
module tb_top;
    import slnu_pkg::*;

    // one input transaction and one output transaction
    typedef struct {
        logic       action;
        logic [7:0] in_byte;
    } t_src_item;

    typedef struct {
        logic [7:0]  out_byte;
        logic [12:0] spaces_before;
        logic        end_of_line;
        logic        line_too_long;
        logic        last;
    } t_line_byte;

    localparam int LINE_BYTES_MAX = LINE_LEN_DEF - LIMIT_MARGIN;
    localparam int RES_PER_ITEM   = 16;
    localparam int SETTLE_CYCLES  = 40;
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    logic clk;
    logic rst_n;
    int   errors;

    slnu_cfg_if cfg_if ();
    slnu_in_if  in_if ();
    slnu_out_if out_if ();

    source_text_line_normalizer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // clock and reset
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor state
    // ------------------------------------------------------------------
    logic        pr_decode;
    logic [2:0]  pr_mode;
    logic        pr_first_seen;
    logic [31:0] pr_acc;
    logic [31:0] pr_prev;
    logic [2:0]  pr_cont_left;
    logic [2:0]  pr_cont_total;
    logic [8:0]  pr_held;
    logic [12:0] pr_line_cnt;
    logic [12:0] pr_space_cnt;
    logic        pr_stopped;
    int          step_results;

    t_line_byte  line_bytes_due[$];

    task automatic emit_byte(input logic [7:0] b, input logic [12:0] sp, input logic eol,
                             input logic tl);
        t_line_byte r;
        if (step_results >= RES_PER_ITEM) return;
        r.out_byte      = b;
        r.spaces_before = sp;
        r.end_of_line   = eol;
        r.line_too_long = tl;
        r.last          = 1'b0;
        line_bytes_due.push_back(r);
        step_results++;
    endtask

    task automatic close_line(input logic too_long);
        emit_byte(8'h00, 13'd0, 1'b1, too_long);
        pr_space_cnt = 0;
        pr_line_cnt  = 0;
    endtask

    // utf-8 encode one code point, spaces are held back
    task automatic encode_cp(input logic [31:0] cp);
        logic [7:0]  seq[6];
        int          n;
        logic [31:0] v;
        if (cp == CP_SPACE) begin
            pr_space_cnt++;
            pr_line_cnt++;
            return;
        end
        if (cp == 0) begin
            seq[0] = 8'hc0; seq[1] = 8'h80; n = 2;
        end else if (cp < 32'h80) begin
            seq[0] = cp[7:0]; n = 1;
        end else begin
            n = cp < 32'h800 ? 2 : cp < 32'h10000 ? 3 : cp < 32'h200000 ? 4 :
                cp < 32'h4000000 ? 5 : 6;
            v = cp;
            for (int k = n - 1; k >= 1; k--) begin
                seq[k] = 8'h80 | v[5:0];
                v = v >> 6;
            end
            seq[0] = 8'((16'hff00 >> n) & 16'hff) | (v[7:0] & 8'(8'hff >> (n + 1)));
        end
        for (int k = 0; k < n; k++)
            emit_byte(seq[k], k == 0 ? pr_space_cnt : 13'd0, 1'b0, 1'b0);
        pr_space_cnt = 0;
        pr_line_cnt  = pr_line_cnt + 13'(n);
    endtask

    task automatic take_cp(input logic [31:0] cp);
        logic skip;
        if (pr_stopped) return;
        if (cp == CP_LF) begin
            skip    = (pr_prev == CP_CR);
            pr_prev = cp;
            if (!skip) close_line(1'b0);
            return;
        end
        if (cp == CP_CR) begin
            pr_prev = cp;
            close_line(1'b0);
            return;
        end
        pr_prev = cp;
        encode_cp(cp);
        if (pr_line_cnt > LINE_BYTES_MAX) begin
            close_line(1'b1);
            pr_stopped = 1'b1;
        end
    endtask

    // broken utf-8 during detection: the raw bytes go out as latin-1
    task automatic replay_raw();
        logic [2:0]  tot;
        logic [2:0]  used;
        logic [7:0]  b;
        logic [31:0] sh;
        tot  = pr_cont_total;
        used = tot - pr_cont_left;
        if (tot > 5 || used > 4) used = 0;
        sh = pr_acc >> (used * 6);
        b  = 8'((16'hff80 >> tot) & 16'hff) | sh[7:0];
        encode_cp({24'd0, b});
        pr_prev = {24'd0, b};
        for (int k = used; k > 0; k--) begin
            sh = pr_acc >> ((k - 1) * 6);
            b  = {2'b10, sh[5:0]};
            encode_cp({24'd0, b});
            pr_prev = {24'd0, b};
        end
        pr_cont_left  = 0;
        pr_cont_total = 0;
    endtask

    task automatic take_unit(input logic [15:0] u);
        logic pend;
        logic low;
        pend = pr_prev >= CP_HI && pr_prev < CP_LO;
        low  = u >= CP_LO[15:0] && u < CP_SUR_END[15:0];
        if (pend && !low) begin
            take_cp(CP_REPL);
            if (pr_stopped) return;
            pend = 1'b0;
        end
        if (u == CP_SWAP[15:0]) begin
            pr_mode = (pr_mode == MODE_LE) ? MODE_BE : MODE_LE;
            pr_prev = {16'd0, u};
            return;
        end
        if (u == CP_BOM[15:0] || (u >= CP_HI[15:0] && u < CP_LO[15:0])) begin
            pr_prev = {16'd0, u};
            return;
        end
        if (low) begin
            if (pend)
                take_cp((((pr_prev - CP_HI) << 10) | ({16'd0, u} - CP_LO)) + CP_PLANE1);
            else
                take_cp(CP_REPL);
            return;
        end
        take_cp({16'd0, u});
    endtask

    task automatic take_utf16_byte(input logic [7:0] b);
        logic [7:0] h;
        if (!pr_held[8]) begin
            pr_held = {1'b1, b};
            return;
        end
        h       = pr_held[7:0];
        pr_held = 0;
        take_unit(pr_mode == MODE_LE ? {b, h} : {h, b});
    endtask

    task automatic take_utf8_byte(input logic [7:0] b);
        logic [7:0] h;
        int         n;
        if (pr_mode == MODE_UNK && pr_held[8]) begin
            h       = pr_held[7:0];
            pr_held = 0;
            pr_prev = {24'd0, h};
            if (h == 8'hff && b == 8'hfe) begin pr_mode = MODE_LE; return; end
            if (h == 8'hfe && b == 8'hff) begin pr_mode = MODE_BE; return; end
            pr_mode = MODE_LAT;
            take_cp({24'd0, h});
            take_cp({24'd0, b});
            return;
        end
        if (pr_cont_left != 0) begin
            if (b[7:6] == 2'b10) begin
                pr_acc = (pr_acc << 6) | {26'd0, b[5:0]};
                pr_cont_left--;
                if (pr_cont_left == 0) begin
                    pr_mode       = MODE_UTF8;
                    pr_cont_total = 0;
                    if (pr_acc == CP_BOM) pr_prev = pr_acc;
                    else take_cp(pr_acc);
                end
                return;
            end
            if (pr_mode == MODE_UNK) begin
                replay_raw();
                pr_mode = MODE_LAT;
                take_cp({24'd0, b});
                return;
            end
            pr_cont_left  = 0;
            pr_cont_total = 0;
            take_cp(CP_REPL);
            if (pr_stopped) return;
        end
        if (b < 8'h80) begin
            take_cp({24'd0, b});
        end else if (b < 8'hc0) begin
            if (pr_mode == MODE_UNK) begin
                pr_mode = MODE_LAT;
                take_cp({24'd0, b});
            end else begin
                take_cp(CP_REPL);
            end
        end else if (b < 8'hfe) begin
            n = b < 8'he0 ? 1 : b < 8'hf0 ? 2 : b < 8'hf8 ? 3 : b < 8'hfc ? 4 : 5;
            pr_acc        = {24'd0, b & 8'(8'h3f >> n)};
            pr_cont_left  = 3'(n);
            pr_cont_total = 3'(n);
        end else if (pr_mode == MODE_UNK) begin
            pr_held = {1'b1, b};
        end else begin
            take_cp(CP_REPL);
        end
    endtask

    task automatic take_end();
        logic [7:0] h;
        if (pr_decode) begin
            if (pr_mode == MODE_UNK) begin
                if (pr_held[8]) begin
                    h       = pr_held[7:0];
                    pr_held = 0;
                    pr_mode = MODE_LAT;
                    take_cp({24'd0, h});
                end else if (pr_cont_left != 0) begin
                    pr_mode = MODE_LAT;
                    replay_raw();
                end
            end else if (pr_mode == MODE_UTF8) begin
                pr_cont_left  = 0;
                pr_cont_total = 0;
            end else if (pr_mode == MODE_LE || pr_mode == MODE_BE) begin
                pr_held = 0;
                if (pr_prev >= CP_HI && pr_prev < CP_LO) take_cp(CP_REPL);
            end
        end
        if (!pr_stopped) close_line(1'b0);
        pr_stopped = 1'b1;
    endtask

    // expected output transactions for one accepted input transaction
    task automatic predict_line_bytes(input t_src_item it);
        int first;
        first        = line_bytes_due.size();
        step_results = 0;
        if (pr_stopped) return;
        if (it.action == ACT_DATA) begin
            if (!pr_first_seen) begin
                pr_first_seen = 1'b1;
                if (pr_mode == MODE_UNK && it.in_byte == 8'h00) pr_mode = MODE_BE;
            end
            if (!pr_decode) take_cp({24'd0, it.in_byte});
            else if (pr_mode <= MODE_UTF8) take_utf8_byte(it.in_byte);
            else if (pr_mode <= MODE_BE) take_utf16_byte(it.in_byte);
            else take_cp({24'd0, it.in_byte});
        end else begin
            take_end();
        end
        if (line_bytes_due.size() > first)
            line_bytes_due[line_bytes_due.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    t_src_item src_bytes[$];
    int        gen_style;     // 0 utf-8, 1 utf-16le, 2 utf-16be, 3 latin-1
    logic      gen_le;
    logic      src_quiet;
    logic      sink_quiet;
    logic      drv_busy;
    int        accepted_out;

    task automatic push_raw(input logic [7:0] b);
        t_src_item it;
        it.action  = ACT_DATA;
        it.in_byte = b;
        src_bytes.push_back(it);
    endtask

    task automatic push_unit(input logic [15:0] u);
        if (gen_le) begin push_raw(u[7:0]); push_raw(u[15:8]); end
        else begin push_raw(u[15:8]); push_raw(u[7:0]); end
    endtask

    // write one code point in the stream encoding
    task automatic push_cp(input logic [31:0] cp);
        logic [31:0] v;
        int          n;
        logic [7:0]  seq[6];
        if (gen_style == 0) begin
            if (cp < 32'h80) begin
                push_raw(cp[7:0]);
                return;
            end
            n = cp < 32'h800 ? 2 : cp < 32'h10000 ? 3 : cp < 32'h200000 ? 4 :
                cp < 32'h4000000 ? 5 : 6;
            v = cp;
            for (int k = n - 1; k >= 1; k--) begin
                seq[k] = 8'h80 | v[5:0];
                v = v >> 6;
            end
            seq[0] = 8'((16'hff00 >> n) & 16'hff) | v[7:0];
            for (int k = 0; k < n; k++) push_raw(seq[k]);
        end else if (gen_style == 3) begin
            push_raw(cp[7:0]);
        end else if (cp >= CP_PLANE1) begin
            v = cp - CP_PLANE1;
            push_unit(16'hd800 | 16'(v[19:10]));
            push_unit(16'hdc00 | 16'(v[9:0]));
        end else begin
            push_unit(cp[15:0]);
        end
    endtask

    function automatic logic [31:0] rand_cp();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) return 32'($urandom_range(8'h21, 8'h7e));
        if (sel < 50) return CP_SPACE;
        if (sel < 56) return CP_LF;
        if (sel < 62) return CP_CR;
        if (sel < 64) return 32'd0;
        if (sel < 74) return 32'($urandom_range(8'h80, 12'h7ff));
        if (sel < 84) return 32'($urandom_range(12'h800, 16'hd7ff));
        if (sel < 92) return 32'($urandom_range(17'h10000, 21'h10ffff));
        if (gen_style == 0) return {1'b0, 31'($urandom())};
        return 32'($urandom_range(16'he000, 16'hfffd));
    endfunction

    // malformed pieces for the stream encoding
    task automatic push_noise();
        int sel;
        sel = $urandom_range(0, 3);
        case (gen_style)
            0: begin
                if (sel == 0) push_raw(8'($urandom_range(8'h80, 8'hbf)));
                else if (sel == 1) begin
                    push_raw(8'($urandom_range(8'hc0, 8'hfd)));
                    push_raw(8'($urandom_range(0, 8'h7f)));
                end else if (sel == 2) push_raw(8'($urandom_range(8'hfe, 8'hff)));
                else push_cp(CP_BOM);
            end
            1, 2: begin
                if (sel == 0) push_unit(16'($urandom_range(16'hd800, 16'hdbff)));
                else if (sel == 1) push_unit(16'($urandom_range(16'hdc00, 16'hdfff)));
                else if (sel == 2) begin
                    push_unit(CP_SWAP[15:0]);
                    gen_le = ~gen_le;
                end else push_unit(CP_BOM[15:0]);
            end
            default: push_raw(8'($urandom()));
        endcase
    endtask

    task automatic push_random(input int count);
        int target;
        target = src_bytes.size() + count;
        while (src_bytes.size() < target) begin
            if ($urandom_range(0, 9) == 0) push_noise();
            else push_cp(rand_cp());
        end
    endtask

    // wait until every expected output has come and the block is quiet
    task automatic drain();
        while (src_bytes.size() != 0 || drv_busy || line_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_decode(input logic value);
        @(negedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.decode_text <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // stream opening for each encoding
    task automatic push_opening();
        int sel;
        sel = $urandom_range(0, 3);
        case (gen_style)
            0: begin
                if (sel[0]) push_cp(CP_BOM);
                else push_cp(32'h0000_00e9);
            end
            1: begin push_raw(8'hff); push_raw(8'hfe); end
            2: begin
                if (sel[0]) begin push_raw(8'hfe); push_raw(8'hff); end
                else push_cp(32'h0000_0041);  // leading zero selects big endian
            end
            default: begin
                if (sel == 0) push_raw(8'h80);
                else if (sel == 1) begin push_raw(8'hfe); push_raw(8'h41); end
                else if (sel == 2) begin push_raw(8'he2); push_raw(8'h82); push_raw(8'h41); end
                else push_raw(8'hff);
            end
        endcase
    endtask

    task automatic push_directed();
        push_cp(32'h41); push_cp(CP_SPACE); push_cp(CP_SPACE); push_cp(32'h42);
        push_cp(CP_SPACE); push_cp(CP_CR); push_cp(CP_LF); push_cp(CP_LF);
        push_cp(CP_CR); push_cp(32'd0); push_cp(32'h7f); push_cp(32'hff);
        push_cp(CP_CR); push_cp(CP_SPACE); push_cp(CP_LF);
        if (gen_style != 3) begin
            push_cp(32'h20ac); push_cp(CP_BOM); push_cp(32'h10ffff);
        end
        if (gen_style == 0) push_cp(32'h7fff_ffff);
        push_noise(); push_noise(); push_noise(); push_noise();
    endtask

    initial begin
        t_src_item it;
        rst_n              = 1'b0;
        errors             = 0;
        cfg_if.valid       = 1'b0;
        cfg_if.decode_text = 1'b1;
        gen_style          = $urandom_range(0, 3);
        gen_le             = (gen_style == 1);
        src_quiet          = 1'b0;
        sink_quiet         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase 1: decoding on, opening, directed cases, random text
        write_decode(1'b1);
        push_opening();
        push_directed();
        push_random(130);
        drain();

        // phase 2: decoding off, random bytes plus 00, ff, cr and lf as latin-1
        write_decode(1'b0);
        src_quiet  = 1'b1;
        for (int k = 0; k < 70; k++) push_raw(8'($urandom()));
        push_raw(8'h00); push_raw(8'hff); push_raw(CP_CR[7:0]); push_raw(CP_LF[7:0]);
        drain();

        // phase 3: decoding on again, may be mid sequence
        write_decode(1'b1);
        src_quiet  = 1'b0;
        sink_quiet = 1'b1;
        push_random(60);
        while (src_bytes.size() != 0 || drv_busy) @(posedge clk);
        sink_quiet = 1'b0;
        push_random(40);

        // ending: end of input, possibly inside a sequence
        if ($urandom_range(0, 1)) push_raw(8'($urandom_range(8'hc0, 8'hff)));
        it.action  = ACT_END;
        it.in_byte = 8'($urandom());
        src_bytes.push_back(it);
        push_raw(8'h41);
        drain();

        if (errors == 0 && line_bytes_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // input driver: one transaction at a time from the pending queue
    // ------------------------------------------------------------------
    logic in_fire;
    int   src_gap;

    initial begin
        in_if.valid   = 1'b0;
        in_if.action  = ACT_DATA;
        in_if.in_byte = 8'h00;
        drv_busy      = 1'b0;
        src_gap       = 0;
    end

    always @(negedge clk) begin
        logic       nxt_valid;
        t_src_item  it;
        nxt_valid = in_if.valid;
        if (drv_busy && in_fire) begin
            drv_busy  = 1'b0;
            nxt_valid = 1'b0;
            src_gap   = src_quiet ? 0 :
                        ($urandom_range(0, 2) == 0 ? $urandom_range(0, 18) : 0);
        end
        if (!drv_busy && rst_n) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (src_bytes.size() != 0) begin
                it = src_bytes.pop_front();
                in_if.action  <= it.action;
                in_if.in_byte <= it.in_byte;
                nxt_valid = 1'b1;
                drv_busy  = 1'b1;
            end
        end
        in_if.valid <= nxt_valid;
    end

    // ------------------------------------------------------------------
    // output ready with random stalls and one long hold-off
    // ------------------------------------------------------------------
    int   sink_gap;
    int   hold_left;
    logic hold_done;

    initial begin
        out_if.ready = 1'b0;
        sink_gap     = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
    end

    always @(negedge clk) begin
        if (!hold_done && accepted_out >= 60) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (sink_quiet) begin
            out_if.ready <= 1'b1;
        end else if (sink_gap > 0) begin
            sink_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            sink_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: prediction on accepted inputs, checks on accepted outputs
    // ------------------------------------------------------------------
    initial begin
        in_fire      = 1'b0;
        accepted_out = 0;
        pr_decode     = 1'b1;
        pr_mode       = MODE_UNK;
        pr_first_seen = 1'b0;
        pr_acc        = 0;
        pr_prev       = 0;
        pr_cont_left  = 0;
        pr_cont_total = 0;
        pr_held       = 0;
        pr_line_cnt   = 0;
        pr_space_cnt  = 0;
        pr_stopped    = 1'b0;
    end

    always @(posedge clk) begin
        t_src_item  it;
        t_line_byte exp_b;
        t_line_byte got;
        in_fire = rst_n && in_if.valid && in_if.ready;
        if (rst_n && cfg_if.valid && cfg_if.ready) pr_decode = cfg_if.decode_text;
        if (in_fire) begin
            it.action  = in_if.action;
            it.in_byte = in_if.in_byte;
            predict_line_bytes(it);
        end
        if (rst_n && out_if.valid && out_if.ready) begin
            accepted_out++;
            got.out_byte      = out_if.out_byte;
            got.spaces_before = out_if.spaces_before;
            got.end_of_line   = out_if.end_of_line;
            got.line_too_long = out_if.line_too_long;
            got.last          = out_if.last;
            if (line_bytes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected output byte %02h", $time, got.out_byte);
            end else begin
                exp_b = line_bytes_due.pop_front();
                if (got.out_byte != exp_b.out_byte) begin
                    errors++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, exp_b.out_byte, got.out_byte);
                end
                if (got.spaces_before != exp_b.spaces_before) begin
                    errors++;
                    $display("%0t: spaces_before expected %0d actual %0d",
                             $time, exp_b.spaces_before, got.spaces_before);
                end
                if (got.end_of_line != exp_b.end_of_line) begin
                    errors++;
                    $display("%0t: end_of_line expected %0b actual %0b",
                             $time, exp_b.end_of_line, got.end_of_line);
                end
                if (got.line_too_long != exp_b.line_too_long) begin
                    errors++;
                    $display("%0t: line_too_long expected %0b actual %0b",
                             $time, exp_b.line_too_long, got.line_too_long);
                end
                if (got.last != exp_b.last) begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, exp_b.last, got.last);
                end
            end
        end
    end

endmodule
